// ===== design/bir_pkg.sv =====
`timescale 1ns / 1ps

package bir_pkg;

  localparam int STEP_W  = 25;
  localparam int DIM_W   = 9;
  localparam int COORD_W = 8;
  localparam int FRAC_W  = 8;
  localparam int PROD_W  = STEP_W + COORD_W + 1;
  localparam int WGT_W   = 17;
  localparam int ACC_W   = 25;

  localparam logic [PROD_W-1:0] HALF_Q17  = PROD_W'(65536);
  localparam logic [ACC_W-1:0]  ROUND_Q16 = ACC_W'(32768);
  localparam logic [8:0]        WGT_ONE   = 9'd256;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [1:0] REG_SRC_W  = 2'd0;
  localparam logic [1:0] REG_SRC_H  = 2'd1;
  localparam logic [1:0] REG_STEP_X = 2'd2;
  localparam logic [1:0] REG_STEP_Y = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MULX  = 7'b0000010,
    ST_MULY  = 7'b0000100,
    ST_MAPY  = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

endpackage

// ===== design/bilinear_image_resize_unit.sv =====
`timescale 1ns / 1ps

// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tdata: column,row,red,green,blue; tuser: command
// out_     out  out_tvalid/out_tready tdata: red,green,blue
// cfg_     in   cfg_wr_en            cfg_addr, cfg_wdata
//
// Load: written into the frame store at the transfer if column and row are in range.
// Compute: after the transfer, the x and y products on the shared coordinate multiplier,
// the y map, four reads of the single-port frame store feeding one MAC, a drain and the
// result state, then ready again. The result is registered into the output at the result state.
// A waiting output register holds the next item back at the result cycle.
// Synchronous active-low reset clears control and sets config to its defaults; the frame store is not cleared.

module bilinear_image_resize_unit import bir_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CHANNELS   = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [39:0]         in_tdata,   // column, row, red_in, green_in, blue_in
  input  logic                in_tuser,   // command
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // red_out, green_out, blue_out
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_addr,
  input  logic [STEP_W-1:0]   cfg_wdata
);

  localparam int LANES = (CHANNELS < 3) ? CHANNELS : 3;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SZW   = $clog2(MAXD + 1);

  logic [DIM_W-1:0]   src_w_r, src_h_r;
  logic [STEP_W-1:0]  step_x_r, step_y_r;
  state_t             state_r, state_nxt;
  logic [COORD_W-1:0] col_r, row_r;
  logic [SZW-1:0]     sx_r, sy_r;
  logic [FRAC_W-1:0]  fx_r, fy_r;
  logic [1:0]         nb_r;
  logic [WGT_W-1:0]   weight_r;
  mac_ctl_t           mac_ctl_r;
  logic               out_tvalid_r;
  logic [23:0]        out_tdata_r;

  logic [SZW-1:0]     eff_w, eff_h, wlim, hlim, map_lim, map_idx;
  logic [FRAC_W-1:0]  map_frac;
  logic [COORD_W-1:0] map_coord;
  logic [STEP_W-1:0]  map_step;
  logic               in_xfer, load_ok, mem_we;
  logic [AW-1:0]      ld_addr, rd_addr, mem_addr;
  logic [LANES*8-1:0] mem_rdata, mac_res;
  logic [8:0]         wx, wy;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= DIM_W'(96);
      src_h_r  <= DIM_W'(96);
      step_x_r <= STEP_W'(65536);
      step_y_r <= STEP_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SRC_W:  src_w_r  <= cfg_wdata[DIM_W-1:0];
        REG_SRC_H:  src_h_r  <= cfg_wdata[DIM_W-1:0];
        REG_STEP_X: step_x_r <= cfg_wdata;
        REG_STEP_Y: step_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_w_r < DIM_W'(2))      eff_w = SZW'(2);
    else if (32'(src_w_r) > MAX_WIDTH) eff_w = SZW'(MAX_WIDTH);
    else                          eff_w = SZW'(src_w_r);
    if (src_h_r < DIM_W'(2))      eff_h = SZW'(2);
    else if (32'(src_h_r) > MAX_HEIGHT) eff_h = SZW'(MAX_HEIGHT);
    else                          eff_h = SZW'(src_h_r);
  end

  assign wlim = eff_w - SZW'(2);
  assign hlim = eff_h - SZW'(2);

  // shared coordinate unit: x product in MULX, y product in MULY
  assign map_coord = (state_r == ST_MULX) ? col_r : row_r;
  assign map_step  = (state_r == ST_MULX) ? step_x_r : step_y_r;
  assign map_lim   = (state_r == ST_MULY) ? wlim : hlim;

  bir_axis_map #(.SZW(SZW)) u_map (
    .clk   (clk),
    .coord (map_coord),
    .step  (map_step),
    .limit (map_lim),
    .idx   (map_idx),
    .frac  (map_frac)
  );

  assign load_ok = (32'(in_tdata[7:0]) < MAX_WIDTH) && (32'(in_tdata[15:8]) < MAX_HEIGHT);
  assign mem_we  = in_xfer && (in_tuser == CMD_LOAD) && load_ok;
  assign ld_addr = AW'(32'(in_tdata[15:8]) * MAX_WIDTH + 32'(in_tdata[7:0]));
  assign rd_addr = AW'((32'(sy_r) + 32'(nb_r[1])) * MAX_WIDTH + 32'(sx_r) + 32'(nb_r[0]));
  assign mem_addr = mem_we ? ld_addr : rd_addr;

  bir_frame_store #(.DEPTH(DEPTH), .DW(LANES*8)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_tdata[16 +: LANES*8]),
    .rdata (mem_rdata)
  );

  assign wx = nb_r[0] ? {1'b0, fx_r} : WGT_ONE - {1'b0, fx_r};
  assign wy = nb_r[1] ? {1'b0, fy_r} : WGT_ONE - {1'b0, fy_r};

  bir_mac #(.LANES(LANES)) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl_r),
    .weight (weight_r),
    .pix    (mem_rdata),
    .result (mac_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer && in_tuser == CMD_COMPUTE) state_nxt = ST_MULX;
      ST_MULX:  state_nxt = ST_MULY;
      ST_MULY:  state_nxt = ST_MAPY;
      ST_MAPY:  state_nxt = ST_READ;
      ST_READ:  if (nb_r == 2'd3) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      nb_r         <= '0;
      mac_ctl_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mac_ctl_r.en  <= (state_r == ST_READ);
      mac_ctl_r.clr <= (state_r == ST_READ) && (nb_r == 2'd0);
      if (state_r == ST_READ) nb_r <= nb_r + 2'd1;
      else                    nb_r <= '0;
      if (state_r == ST_FIN && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tready)                                    out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      col_r <= in_tdata[7:0];
      row_r <= in_tdata[15:8];
    end
    if (state_r == ST_MULY) begin
      sx_r <= map_idx;
      fx_r <= map_frac;
    end
    if (state_r == ST_MAPY) begin
      sy_r <= map_idx;
      fy_r <= map_frac;
    end
    weight_r <= WGT_W'(wx) * WGT_W'(wy);
    if (state_r == ST_FIN && (!out_tvalid_r || out_tready)) out_tdata_r <= 24'(mac_res);
  end

endmodule

// ===== design/bir_axis_map.sv =====
`timescale 1ns / 1ps

module bir_axis_map import bir_pkg::*; #(
  parameter int SZW = 9
) (
  input  logic                clk,
  input  logic [COORD_W-1:0]  coord,
  input  logic [STEP_W-1:0]   step,
  input  logic [SZW-1:0]      limit,
  output logic [SZW-1:0]      idx,
  output logic [FRAC_W-1:0]   frac
);

  localparam int IP_W = PROD_W - 17;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] v;
  logic [IP_W-1:0]   ip;
  logic              neg;
  logic              over;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'({coord, 1'b1}) * PROD_W'(step);
  end

  // coordinate = (2d+1)*step - 0.5 in Q.17
  assign v    = prod_r - HALF_Q17;
  assign ip   = v[PROD_W-1:17];
  assign neg  = (prod_r < HALF_Q17);
  assign over = (ip > IP_W'(limit));

  always_comb begin
    if (neg) begin
      idx  = '0;
      frac = '0;
    end else if (over) begin
      idx  = limit;
      frac = '0;
    end else begin
      idx  = ip[SZW-1:0];
      frac = v[16:9];
    end
  end

endmodule

// ===== design/bir_frame_store.sv =====
`timescale 1ns / 1ps

module bir_frame_store #(
  parameter int DEPTH = 65536,
  parameter int DW    = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DW-1:0]            wdata,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/bir_mac.sv =====
`timescale 1ns / 1ps

module bir_mac import bir_pkg::*; #(
  parameter int LANES = 3
) (
  input  logic                 clk,
  input  mac_ctl_t             ctl,
  input  logic [WGT_W-1:0]     weight,
  input  logic [LANES*8-1:0]   pix,
  output logic [LANES*8-1:0]   result
);

  logic [ACC_W-1:0] acc_r [LANES];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int c = 0; c < LANES; c++) begin
        acc_r[c] <= (ctl.clr ? '0 : acc_r[c]) + ACC_W'(pix[c*8 +: 8]) * ACC_W'(weight);
      end
    end
  end

  always_comb begin
    logic [ACC_W-1:0] rnd;
    for (int c = 0; c < LANES; c++) begin
      rnd = acc_r[c] + ROUND_Q16;
      result[c*8 +: 8] = (rnd[ACC_W-1:24] != '0) ? 8'hFF : rnd[23:16];
    end
  end

endmodule

// ===== design/bir_chk.sv =====
`timescale 1ns / 1ps

module bir_chk import bir_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_COMPUTE |=> !in_tready ##1 !in_tready)
    else $error("compute transfer did not block input");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_LOAD |=> in_tready)
    else $error("load transfer blocked input");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without compute");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bilinear_image_resize_unit bir_chk u_bir_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
